### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication checked on every rising clk edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### rtl/kpc_pkg.sv
// ----------------------------------------------------------------------------
// kpc_pkg
// Types, constants and register map of the key press classifier.
// ----------------------------------------------------------------------------
package kpc_pkg;

	localparam int OFFSET_WIDTH_DEF = 16;

	localparam int CFG_AW = 5;

	localparam logic [2:0] REG_DEBOUNCE   = 3'd0;
	localparam logic [2:0] REG_LONG_PRESS = 3'd1;
	localparam logic [2:0] REG_SEEK_MAX   = 3'd2;
	localparam logic [2:0] REG_REPEAT     = 3'd3;
	localparam logic [2:0] REG_VISIBLE    = 3'd4;
	localparam logic [2:0] REG_SCROLL_DIV = 3'd5;

	localparam logic [15:0] DEBOUNCE_RST   = 16'd30;
	localparam logic [15:0] LONG_PRESS_RST = 16'd300;
	localparam logic [2:0]  SEEK_MAX_RST   = 3'd4;
	localparam logic [15:0] REPEAT_RST     = 16'd400;
	localparam logic [15:0] VISIBLE_RST    = 16'd128;
	localparam logic [3:0]  SCROLL_DIV_RST = 4'd2;

	localparam int unsigned SEEK_STEP_MS = 5000;
	localparam logic [2:0]  SEEK_BASE    = 3'd2;
	localparam int          SEEK_STEPS   = 5;

	localparam logic [1:0] PLAY_NONE = 2'd0;
	localparam logic [1:0] PLAY_PREV = 2'd1;
	localparam logic [1:0] PLAY_NEXT = 2'd2;

	localparam logic [1:0] VOL_NONE = 2'd0;
	localparam logic [1:0] VOL_UP   = 2'd1;
	localparam logic [1:0] VOL_DOWN = 2'd2;

	typedef struct packed {
		logic [15:0] debounce_ms;
		logic [15:0] long_press_ms;
		logic [2:0]  seek_max;
		logic [15:0] repeat_ms;
		logic [15:0] visible_width;
		logic [3:0]  scroll_divide;
	} cfg_t;

	typedef struct packed {
		logic              short_press;
		logic              seek_valid;
		logic signed [3:0] seek_velocity;
	} track_res_t;

	// first member is the MSB: fields listed high to low
	typedef struct packed {
		logic        pad;
		logic [15:0] text_width;
		logic        rewind_blocked;
		logic        vol_down_level;
		logic        vol_up_level;
		logic        next_press;
		logic        prev_press;
		logic        next_level;
		logic        prev_level;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [5:0]        pad;
		logic              scroll_moved;
		logic [15:0]       scroll_offset;
		logic [1:0]        volume_step;
		logic signed [3:0] seek_velocity;
		logic              seek_valid;
		logic [1:0]        play_command;
	} out_item_t;

endpackage

### rtl/kpc_regs.sv
// ----------------------------------------------------------------------------
// kpc_regs
// APB configuration registers.
// ----------------------------------------------------------------------------
module kpc_regs import kpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready;
	assign idx    = paddr[CFG_AW-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= DEBOUNCE_RST;
			cfg_q.long_press_ms <= LONG_PRESS_RST;
			cfg_q.seek_max      <= SEEK_MAX_RST;
			cfg_q.repeat_ms     <= REPEAT_RST;
			cfg_q.visible_width <= VISIBLE_RST;
			cfg_q.scroll_divide <= SCROLL_DIV_RST;
		end else if (wr) begin
			unique case (idx)
				REG_DEBOUNCE:   cfg_q.debounce_ms   <= pwdata[15:0];
				REG_LONG_PRESS: cfg_q.long_press_ms <= pwdata[15:0];
				REG_SEEK_MAX:   cfg_q.seek_max      <= pwdata[2:0];
				REG_REPEAT:     cfg_q.repeat_ms     <= pwdata[15:0];
				REG_VISIBLE:    cfg_q.visible_width <= pwdata[15:0];
				REG_SCROLL_DIV: cfg_q.scroll_divide <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DEBOUNCE:   prdata = {16'd0, cfg_q.debounce_ms};
			REG_LONG_PRESS: prdata = {16'd0, cfg_q.long_press_ms};
			REG_SEEK_MAX:   prdata = {29'd0, cfg_q.seek_max};
			REG_REPEAT:     prdata = {16'd0, cfg_q.repeat_ms};
			REG_VISIBLE:    prdata = {16'd0, cfg_q.visible_width};
			REG_SCROLL_DIV: prdata = {28'd0, cfg_q.scroll_divide};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

### rtl/kpc_track.sv
// ----------------------------------------------------------------------------
// kpc_track
// Hold-time classifier for one track key: short press, seek, seek stop.
// ----------------------------------------------------------------------------
module kpc_track import kpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [31:0] now_ms,
	input  logic        level,
	input  logic        press,
	input  logic        may_seek,
	input  logic        rewind,
	input  cfg_t        cfg,
	output track_res_t  res
);

	logic        armed_q;
	logic [31:0] start_q;
	logic        armed_now;
	logic [31:0] start_now;
	logic [31:0] held;
	logic [31:0] over;
	logic        release_k;
	logic        is_long;
	logic [2:0]  q;
	logic [2:0]  s;
	logic [2:0]  mag;

	assign armed_now = press | armed_q;
	assign start_now = press ? now_ms : start_q;
	assign held      = now_ms - start_now;
	assign over      = held - {16'd0, cfg.long_press_ms};
	assign release_k = ~level & armed_now;
	assign is_long   = held >= {16'd0, cfg.long_press_ms};

	// steps of 5000 ms past the long press point, capped where the limit takes over
	always_comb begin
		q = 3'd0;
		for (int k = 1; k <= SEEK_STEPS; k++) begin
			if (over >= 32'(k * SEEK_STEP_MS))
				q = 3'(k);
		end
	end

	assign s   = SEEK_BASE + q;
	assign mag = (s > cfg.seek_max) ? cfg.seek_max : s;

	always_comb begin
		res = '0;
		if (release_k) begin
			if (held >= {16'd0, cfg.debounce_ms}) begin
				if (!is_long)
					res.short_press = 1'b1;
				else
					res.seek_valid = 1'b1;
			end
		end else if (level && armed_now && is_long && may_seek) begin
			res.seek_valid    = 1'b1;
			res.seek_velocity = rewind ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			start_q <= 32'd0;
		end else if (fire) begin
			armed_q <= armed_now & ~release_k;
			start_q <= start_now;
		end
	end

endmodule

### rtl/kpc_volume.sv
// ----------------------------------------------------------------------------
// kpc_volume
// Volume key step on press and auto-repeat while held.
// ----------------------------------------------------------------------------
module kpc_volume import kpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [31:0] now_ms,
	input  logic        up,
	input  logic        down,
	input  cfg_t        cfg,
	output logic [1:0]  step
);

	logic [1:0]  held_q;
	logic [31:0] mark_q;
	logic [1:0]  held_d;
	logic [31:0] mark_d;
	logic [1:0]  vkey;
	logic [31:0] elapsed;

	assign vkey    = up ? VOL_UP : (down ? VOL_DOWN : VOL_NONE);
	assign elapsed = now_ms - mark_q;

	always_comb begin
		step   = VOL_NONE;
		held_d = held_q;
		mark_d = mark_q;
		if (vkey != VOL_NONE) begin
			if (vkey != held_q) begin
				held_d = vkey;
				mark_d = now_ms;
				step   = vkey;
			end else if (elapsed >= {16'd0, cfg.repeat_ms}) begin
				mark_d = now_ms;
				step   = vkey;
			end
		end else begin
			held_d = VOL_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= VOL_NONE;
			mark_q <= 32'd0;
		end else if (fire) begin
			held_q <= held_d;
			mark_q <= mark_d;
		end
	end

endmodule

### rtl/kpc_scroll.sv
// ----------------------------------------------------------------------------
// kpc_scroll
// Title marquee offset: tick divider and wrapping offset counter.
// ----------------------------------------------------------------------------
module kpc_scroll import kpc_pkg::*; #(
	parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [15:0] text_width,
	input  cfg_t        cfg,
	output logic [15:0] offset,
	output logic        moved
);

	localparam int CW = (OFFSET_WIDTH > 16) ? OFFSET_WIDTH : 16;

	logic [3:0]              ticks_q;
	logic [OFFSET_WIDTH-1:0] offset_q;
	logic [3:0]              ticks_d;
	logic [OFFSET_WIDTH-1:0] offset_d;
	logic [3:0]              ticks_inc;
	logic [OFFSET_WIDTH-1:0] offset_inc;

	assign ticks_inc  = ticks_q + 4'd1;
	assign offset_inc = offset_q + OFFSET_WIDTH'(1);

	always_comb begin
		ticks_d  = ticks_q;
		offset_d = offset_q;
		moved    = 1'b0;
		if (text_width > cfg.visible_width) begin
			ticks_d = ticks_inc;
			if (ticks_inc >= cfg.scroll_divide) begin
				ticks_d  = 4'd0;
				moved    = 1'b1;
				offset_d = (CW'(offset_inc) >= CW'(text_width)) ? '0 : offset_inc;
			end
		end
	end

	assign offset = 16'(offset_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q  <= 4'd0;
			offset_q <= '0;
		end else if (fire) begin
			ticks_q  <= ticks_d;
			offset_q <= offset_d;
		end
	end

endmodule

### rtl/key_press_classifier_with_marquee_unit.sv
// Key press classifier with title marquee. One tick item is taken per clock
// cycle unless the result side stalls, and each gives exactly one result item;
// it passes through the input register, one stage of compare and update logic
// that also updates the key and scroll state, and the result register. While a
// result waits, one more tick can still enter the input register; once that is
// full the input side waits until the result is taken.
// ----------------------------------------------------------------------------
// key_press_classifier_with_marquee_unit
// Track key short/long press, seek speed, volume repeat and title scroll.
// ----------------------------------------------------------------------------
module key_press_classifier_with_marquee_unit import kpc_pkg::*; #(
	parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// now_ms[31:0], prev_level, next_level, prev_press, next_press,
	// vol_up_level, vol_down_level, rewind_blocked, text_width[15:0], pad
	input  logic [55:0]       s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// play_command[1:0], seek_valid, seek_velocity[3:0], volume_step[1:0],
	// scroll_offset[15:0], scroll_moved, pad
	output logic [31:0]       m_tdata,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t       cfg;
	in_item_t   item_s1;
	logic       valid_s1;
	out_item_t  res_q;
	logic       res_valid_q;
	out_item_t  res_d;
	logic       out_free;
	logic       fire;
	track_res_t prev_res;
	track_res_t next_res;
	logic [1:0] vol_step;
	logic [15:0] offset;
	logic       moved;

	assign out_free = ~res_valid_q | m_tready;
	assign fire     = valid_s1 & out_free;
	assign s_tready = ~valid_s1 | out_free;
	assign m_tvalid = res_valid_q;
	assign m_tdata  = res_q;

	kpc_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	kpc_track u_prev (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.now_ms  (item_s1.now_ms),
		.level   (item_s1.prev_level),
		.press   (item_s1.prev_press),
		.may_seek(~item_s1.rewind_blocked),
		.rewind  (1'b1),
		.cfg     (cfg),
		.res     (prev_res)
	);

	kpc_track u_next (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.now_ms  (item_s1.now_ms),
		.level   (item_s1.next_level),
		.press   (item_s1.next_press),
		.may_seek(1'b1),
		.rewind  (1'b0),
		.cfg     (cfg),
		.res     (next_res)
	);

	kpc_volume u_volume (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.now_ms(item_s1.now_ms),
		.up    (item_s1.vol_up_level),
		.down  (item_s1.vol_down_level),
		.cfg   (cfg),
		.step  (vol_step)
	);

	kpc_scroll #(
		.OFFSET_WIDTH(OFFSET_WIDTH)
	) u_scroll (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.text_width(item_s1.text_width),
		.cfg       (cfg),
		.offset    (offset),
		.moved     (moved)
	);

	// next key wins when both act in one tick
	always_comb begin
		res_d = '0;
		if (next_res.short_press)
			res_d.play_command = PLAY_NEXT;
		else if (prev_res.short_press)
			res_d.play_command = PLAY_PREV;
		res_d.seek_valid = prev_res.seek_valid | next_res.seek_valid;
		if (next_res.seek_valid)
			res_d.seek_velocity = next_res.seek_velocity;
		else if (prev_res.seek_valid)
			res_d.seek_velocity = prev_res.seek_velocity;
		res_d.volume_step   = vol_step;
		res_d.scroll_offset = offset;
		res_d.scroll_moved  = moved;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (out_free)
				res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			item_s1 <= in_item_t'(s_tdata);
		if (fire)
			res_q <= res_d;
	end

endmodule

### rtl/kpc_checker.sv
// ----------------------------------------------------------------------------
// kpc_checker
// Port-level checks of the key press classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        pready
);

	`ASSERT_CLK(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result not held")
	`ASSERT_IMPL(a_seek_zero, m_tvalid && !m_tdata[2], m_tdata[6:3] == 4'd0, "stray seek value")
	`ASSERT_IMPL(a_codes, m_tvalid, m_tdata[1:0] != 2'd3 && m_tdata[8:7] != 2'd3, "bad code")
	`ASSERT_CLK(a_accept_out, s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid, "no result")
	`ASSERT_CLK(a_pready, pready, "pready low")

endmodule

bind key_press_classifier_with_marquee_unit kpc_checker u_kpc_checker (.*);

### sim/tb_key_press_classifier_with_marquee_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_key_press_classifier_with_marquee_unit
// Drives tick items into the key classifier, predicts every result item from
// a local copy of the key, volume and scroll state, and checks each result
// field by field. A directed run comes first, then random press, hold and
// release sequences under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_key_press_classifier_with_marquee_unit;
	import kpc_pkg::*;

	typedef enum int {SET_RESET, SET_MIN, SET_MAX, SET_SKEW, SET_RANDOM} setting_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [55:0]       s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [31:0]       m_tdata;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	// predictor copy of registers and state
	cfg_t        cfg;
	logic        prev_armed, next_armed;
	logic [31:0] prev_since, next_since;
	logic [1:0]  vol_held;
	logic [31:0] vol_mark;
	logic [3:0]  marquee_ticks;
	logic [15:0] marquee_pos;

	out_item_t   expected_results[$];
	int          mismatches = 0;
	int          results_seen = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;

	// stimulus-side key state
	logic        prev_down = 1'b0, next_down = 1'b0;
	logic [1:0]  vol_keys = 2'd0;
	logic [15:0] title_width = 16'd200;
	logic [31:0] clock_ms = 32'd0;

	key_press_classifier_with_marquee_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [3:0] seek_rate(input logic [31:0] held);
		logic [31:0] q;
		logic [3:0]  s;
		q = (held - {16'd0, cfg.long_press_ms}) / SEEK_STEP_MS;
		s = (q > 32'd7) ? 4'd9 : 4'(SEEK_BASE + q);
		if (s > {1'b0, cfg.seek_max})
			s = {1'b0, cfg.seek_max};
		return s;
	endfunction

	task automatic classify_track(input logic [31:0] now, input logic level,
			input logic may_seek, input logic rewind, inout logic armed,
			input logic [31:0] since, inout logic sv, inout logic [3:0] spd,
			output logic short_rel);
		logic [31:0] held;
		logic [3:0]  s;
		held = now - since;
		short_rel = 1'b0;
		if (!level && armed) begin
			armed = 1'b0;
			if (held >= {16'd0, cfg.debounce_ms}) begin
				if (held < {16'd0, cfg.long_press_ms}) begin
					short_rel = 1'b1;
				end else begin
					sv = 1'b1;
					spd = 4'd0;
				end
			end
		end else if (level && armed && held >= {16'd0, cfg.long_press_ms} && may_seek) begin
			s = seek_rate(held);
			sv = 1'b1;
			spd = rewind ? (4'd0 - s) : s;
		end
	endtask

	task automatic predict_tick(input in_item_t t, output out_item_t r);
		logic        sv, sp_prev, sp_next;
		logic [3:0]  spd;
		logic [1:0]  vk;
		logic [15:0] off;
		r = '0;
		sv = 1'b0;
		spd = 4'd0;
		if (t.prev_press) begin
			prev_armed = 1'b1;
			prev_since = t.now_ms;
		end
		if (t.next_press) begin
			next_armed = 1'b1;
			next_since = t.now_ms;
		end
		classify_track(t.now_ms, t.prev_level, !t.rewind_blocked, 1'b1, prev_armed,
			prev_since, sv, spd, sp_prev);
		classify_track(t.now_ms, t.next_level, 1'b1, 1'b0, next_armed,
			next_since, sv, spd, sp_next);
		r.play_command = sp_next ? PLAY_NEXT : (sp_prev ? PLAY_PREV : PLAY_NONE);
		r.seek_valid = sv;
		r.seek_velocity = spd;

		vk = t.vol_up_level ? VOL_UP : (t.vol_down_level ? VOL_DOWN : VOL_NONE);
		if (vk != VOL_NONE) begin
			if (vk != vol_held) begin
				vol_held = vk;
				vol_mark = t.now_ms;
				r.volume_step = vk;
			end else if ((t.now_ms - vol_mark) >= {16'd0, cfg.repeat_ms}) begin
				vol_mark = t.now_ms;
				r.volume_step = vk;
			end
		end else begin
			vol_held = VOL_NONE;
		end

		if (t.text_width > cfg.visible_width) begin
			marquee_ticks = marquee_ticks + 4'd1;
			if (marquee_ticks >= cfg.scroll_divide) begin
				off = marquee_pos + 16'd1;
				marquee_ticks = 4'd0;
				if (off >= t.text_width)
					off = 16'd0;
				marquee_pos = off;
				r.scroll_moved = 1'b1;
			end
		end
		r.scroll_offset = marquee_pos;
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("ERROR result %0d %s: got %0h expected %0h", results_seen, field,
			got, want);
		mismatches++;
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		results_seen++;
		if (expected_results.size() == 0) begin
			report_mismatch("unexpected item", got, 32'd0);
			return;
		end
		want = expected_results.pop_front();
		if (got.play_command !== want.play_command)
			report_mismatch("play_command", 32'(got.play_command), 32'(want.play_command));
		if (got.seek_valid !== want.seek_valid)
			report_mismatch("seek_valid", 32'(got.seek_valid), 32'(want.seek_valid));
		if (got.seek_velocity !== want.seek_velocity)
			report_mismatch("seek_velocity", 32'(got.seek_velocity),
				32'(want.seek_velocity));
		if (got.volume_step !== want.volume_step)
			report_mismatch("volume_step", 32'(got.volume_step), 32'(want.volume_step));
		if (got.scroll_offset !== want.scroll_offset)
			report_mismatch("scroll_offset", 32'(got.scroll_offset),
				32'(want.scroll_offset));
		if (got.scroll_moved !== want.scroll_moved)
			report_mismatch("scroll_moved", 32'(got.scroll_moved), 32'(want.scroll_moved));
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_result(out_item_t'(m_tdata));
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send_tick(input in_item_t t);
		out_item_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= t;
		do @(posedge clk); while (!s_tready);
		predict_tick(t, r);
		expected_results.push_back(r);
	endtask

	task automatic send_keys(input logic [31:0] now, input logic pl, input logic nl,
			input logic pp, input logic np, input logic up, input logic dn,
			input logic blk, input logic [15:0] width);
		in_item_t t;
		t = '0;
		t.now_ms = now;
		t.prev_level = pl;
		t.next_level = nl;
		t.prev_press = pp;
		t.next_press = np;
		t.vol_up_level = up;
		t.vol_down_level = dn;
		t.rewind_blocked = blk;
		t.text_width = width;
		send_tick(t);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_DEBOUNCE:   cfg.debounce_ms = val[15:0];
			REG_LONG_PRESS: cfg.long_press_ms = val[15:0];
			REG_SEEK_MAX:   cfg.seek_max = val[2:0];
			REG_REPEAT:     cfg.repeat_ms = val[15:0];
			REG_VISIBLE:    cfg.visible_width = val[15:0];
			REG_SCROLL_DIV: cfg.scroll_divide = val[3:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input setting_t kind);
		logic [15:0] deb, lng, rep, vis;
		logic [2:0]  smax;
		logic [3:0]  div;
		case (kind)
			SET_RESET: begin
				deb = DEBOUNCE_RST; lng = LONG_PRESS_RST; smax = SEEK_MAX_RST;
				rep = REPEAT_RST; vis = VISIBLE_RST; div = SCROLL_DIV_RST;
			end
			SET_MIN: begin
				deb = 16'd0; lng = 16'd0; smax = 3'd0;
				rep = 16'd0; vis = 16'd0; div = 4'd0;
			end
			SET_MAX: begin
				deb = 16'hFFFF; lng = 16'hFFFF; smax = 3'd7;
				rep = 16'hFFFF; vis = 16'hFFFF; div = 4'd15;
			end
			SET_SKEW: begin
				// debounce beyond long press, seek limit below base speed
				deb = 16'(500 + $urandom_range(0, 3000)); lng = 16'($urandom_range(0, 400));
				smax = 3'd1; rep = 16'($urandom_range(0, 50));
				vis = 16'($urandom_range(0, 64)); div = 4'd1;
			end
			default: begin
				deb = 16'($urandom_range(0, 100)); lng = 16'($urandom_range(0, 2000));
				smax = 3'($urandom_range(2, 7)); rep = 16'($urandom_range(0, 1000));
				vis = 16'($urandom_range(0, 300)); div = 4'($urandom_range(1, 15));
			end
		endcase
		cfg_write(REG_DEBOUNCE, {16'd0, deb});
		cfg_write(REG_LONG_PRESS, {16'd0, lng});
		cfg_write(REG_SEEK_MAX, {29'd0, smax});
		cfg_write(REG_REPEAT, {16'd0, rep});
		cfg_write(REG_VISIBLE, {16'd0, vis});
		cfg_write(REG_SCROLL_DIV, {28'd0, div});
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [31:0] tick_step();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 40)
			return $urandom_range(0, 20);
		if (r < 75)
			return $urandom_range(0, 200);
		if (r < 95)
			return $urandom_range(0, 3000);
		return $urandom_range(0, 70000);
	endfunction

	task automatic random_tick(output in_item_t t);
		t = '0;
		clock_ms = clock_ms + tick_step();
		if ($urandom_range(199) == 0)
			clock_ms = $urandom();
		t.now_ms = clock_ms;
		// mostly clean press / hold / release sequences
		if (!prev_down) begin
			if ($urandom_range(9) == 0) begin
				prev_down = 1'b1;
				t.prev_press = 1'b1;
			end
		end else if ($urandom_range(6) == 0) begin
			prev_down = 1'b0;
		end
		if (!next_down) begin
			if ($urandom_range(9) == 0) begin
				next_down = 1'b1;
				t.next_press = 1'b1;
			end
		end else if ($urandom_range(6) == 0) begin
			next_down = 1'b0;
		end
		t.prev_level = prev_down;
		t.next_level = next_down;
		if ($urandom_range(19) == 0) begin
			t.prev_press = 1'($urandom);
			t.next_press = 1'($urandom);
			t.prev_level = 1'($urandom);
			t.next_level = 1'($urandom);
		end
		if ($urandom_range(7) == 0)
			vol_keys = 2'($urandom);
		t.vol_up_level = vol_keys[0];
		t.vol_down_level = vol_keys[1];
		t.rewind_blocked = ($urandom_range(4) == 0);
		if ($urandom_range(29) == 0) begin
			case ($urandom_range(2))
				0: title_width = 16'($urandom);
				1: title_width = 16'(cfg.visible_width + $urandom_range(1, 40));
				default: title_width = 16'($urandom_range(0, cfg.visible_width));
			endcase
		end
		t.text_width = title_width;
	endtask

	task automatic run_random_phase(input setting_t kind, input int n, input int unsigned idle,
			input int unsigned stall);
		in_item_t t;
		wait_idle();
		apply_settings(kind);
		send_idle_pct = idle;
		stall_pct = stall;
		title_width = 16'(cfg.visible_width + 16'd20);
		repeat (n) begin
			random_tick(t);
			send_tick(t);
		end
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		stall_pct = 0;
		send_keys(32'd0,     0, 0, 0, 0, 0, 0, 0, 16'd0);
		send_keys(32'd100,   1, 0, 1, 0, 0, 0, 0, 16'd200);
		send_keys(32'd110,   0, 0, 0, 0, 0, 0, 0, 16'd200); // bounce, ignored
		send_keys(32'd200,   1, 0, 1, 0, 0, 0, 0, 16'd200);
		send_keys(32'd300,   0, 0, 0, 0, 0, 0, 0, 16'd200); // short prev
		send_keys(32'd400,   0, 1, 0, 1, 0, 0, 0, 16'd200);
		send_keys(32'd500,   0, 0, 0, 0, 0, 0, 0, 16'd200); // short next
		send_keys(32'd1000,  1, 0, 1, 0, 0, 0, 0, 16'd3);
		send_keys(32'd1400,  1, 0, 0, 0, 0, 0, 0, 16'd3);   // rewind seek
		send_keys(32'd11400, 1, 0, 0, 0, 0, 0, 0, 16'd3);   // saturated
		send_keys(32'd11500, 1, 0, 0, 0, 0, 0, 1, 16'd3);   // rewind blocked
		send_keys(32'd11600, 0, 0, 0, 0, 0, 0, 1, 16'd3);   // stop still given
		send_keys(32'd12000, 1, 1, 1, 1, 0, 0, 0, 16'd128);
		send_keys(32'd12100, 0, 0, 0, 0, 0, 0, 0, 16'd129); // both short
		send_keys(32'd12200, 1, 1, 1, 1, 0, 0, 0, 16'd129);
		send_keys(32'd50000, 1, 1, 0, 0, 0, 0, 0, 16'd129); // both seek
		send_keys(32'd50001, 1, 1, 0, 0, 1, 1, 0, 16'd129); // up wins
		send_keys(32'd50100, 0, 0, 0, 0, 1, 0, 0, 16'd129);
		send_keys(32'd50500, 0, 0, 0, 0, 1, 0, 0, 16'd129); // repeat
		send_keys(32'd50600, 0, 0, 0, 0, 0, 1, 0, 16'd129);
		send_keys(32'd50700, 0, 0, 0, 0, 0, 0, 0, 16'd129);
		send_keys(32'hFFFF_FFF0, 0, 1, 0, 1, 1, 0, 0, 16'hFFFF);
		send_keys(32'h0000_0100, 0, 0, 0, 0, 0, 0, 1, 16'hFFFF); // time wraps
		send_keys(32'hFFFF_FFFF, 1, 1, 1, 1, 1, 1, 1, 16'hFFFF);
		send_keys(32'd0,     0, 0, 0, 0, 0, 0, 0, 16'd0);
	endtask

	task automatic test_no_idling();
		run_random_phase(SET_RESET, 150, 0, 0);
		run_random_phase(SET_MIN, 150, 0, 0);
	endtask

	task automatic test_sender_gaps();
		run_random_phase(SET_MAX, 150, 81, 0);
		run_random_phase(SET_RANDOM, 150, 81, 0);
	endtask

	task automatic test_receiver_stalls();
		run_random_phase(SET_SKEW, 150, 0, 81);
		run_random_phase(SET_RANDOM, 150, 0, 81);
	endtask

	task automatic test_both_idle();
		run_random_phase(SET_RANDOM, 150, 6, 6);
		run_random_phase(SET_MIN, 150, 6, 6);
	endtask

	initial begin
		cfg.debounce_ms = DEBOUNCE_RST;
		cfg.long_press_ms = LONG_PRESS_RST;
		cfg.seek_max = SEEK_MAX_RST;
		cfg.repeat_ms = REPEAT_RST;
		cfg.visible_width = VISIBLE_RST;
		cfg.scroll_divide = SCROLL_DIV_RST;
		prev_armed = 1'b0;
		next_armed = 1'b0;
		prev_since = 32'd0;
		next_since = 32'd0;
		vol_held = VOL_NONE;
		vol_mark = 32'd0;
		marquee_ticks = 4'd0;
		marquee_pos = 16'd0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_no_idling();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();

		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("key_press_classifier_with_marquee_unit test passed");
		else
			$display("key_press_classifier_with_marquee_unit test failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("key_press_classifier_with_marquee_unit test failed");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/kpc_pkg.sv
rtl/kpc_regs.sv
rtl/kpc_track.sv
rtl/kpc_volume.sv
rtl/kpc_scroll.sv
rtl/key_press_classifier_with_marquee_unit.sv
rtl/kpc_checker.sv
sim/tb_key_press_classifier_with_marquee_unit.sv
